// ----- rtl/core/pcg4_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcg4_pkg
// Shared types, constants and helper functions of the four-lane pcg32
// generator: lcg constants, jump constants and the xsh-rr output function.
// ----------------------------------------------------------------------------
package pcg4_pkg;

    localparam int unsigned STATE_W     = 64;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned CFG_W       = 64;
    localparam int unsigned PADDR_W     = 4;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] MAX_WORDS = 3'd4;

    localparam logic [STATE_W-1:0] PCG_MULT      = 64'd6364136223846793005;
    localparam logic [STATE_W-1:0] START_DEFAULT = 64'h853c49e6748fea9b;
    localparam logic [STATE_W-1:0] SEQ_DEFAULT   = 64'hda3e39cb94b95bdb;
    localparam logic [STATE_W-1:0] INC_DEFAULT   = {SEQ_DEFAULT[STATE_W-2:0], 1'b1};

    localparam int unsigned XSH_SHIFT_A = 18;
    localparam int unsigned XSH_SHIFT_B = 27;
    localparam int unsigned ROT_LSB     = 59;

    // phases of the shared 32x32 multiply-add sequence in each lane
    localparam logic [1:0] PH_FIRST   = 2'd0;
    localparam logic [1:0] PH_CROSS_A = 2'd1;
    localparam logic [1:0] PH_CROSS_B = 2'd2;
    localparam logic [1:0] PH_LAST    = 2'd3;

    typedef enum logic [1:0] {
        LOP_SCALE,  // state = inc * sum of powers
        LOP_SEED,   // state = base * power + state
        LOP_STEP    // state = state * jump_mult + jump_inc
    } t_lane_op;

    typedef struct packed {
        logic       run;
        t_lane_op   op;
        logic [1:0] phase;
    } t_lane_ctl;

    typedef struct packed {
        logic             restart;
        logic [CNT_W-1:0] count;
    } t_job;

    // M^n, worked out at elaboration
    function automatic logic [STATE_W-1:0] f_mult_pow(input int unsigned n);
        logic [STATE_W-1:0] p;
        p = 64'd1;
        for (int unsigned k = 0; k < n; k++) begin
            p = p * PCG_MULT;
        end
        return p;
    endfunction

    // 1 + M + ... + M^i
    function automatic logic [STATE_W-1:0] f_sum_pow(input int unsigned i);
        logic [STATE_W-1:0] s;
        s = 64'd0;
        for (int unsigned k = 0; k <= i; k++) begin
            s = s * PCG_MULT + 64'd1;
        end
        return s;
    endfunction

    // lane state after reset (default stream and start)
    function automatic logic [STATE_W-1:0] f_lane_reset(input int unsigned i);
        return (INC_DEFAULT + START_DEFAULT) * f_mult_pow(i + 1)
               + INC_DEFAULT * f_sum_pow(i);
    endfunction

    function automatic logic [WORD_W-1:0] f_xsh_rr(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0]  mix;
        logic [WORD_W-1:0]   x;
        logic [4:0]          r;
        logic [2*WORD_W-1:0] dbl;
        mix = ((s >> XSH_SHIFT_A) ^ s) >> XSH_SHIFT_B;
        x   = mix[WORD_W-1:0];
        r   = s[STATE_W-1:ROT_LSB];
        dbl = {x, x} >> r;
        return dbl[WORD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pcg4_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcg4_front
// Accepts requests, saturates the word count, drops empty requests and
// queues jobs for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module pcg4_front
    import pcg4_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [CNT_W-1:0] i_s_count,
    input  wire logic             i_s_restart,
    output logic                  o_job_valid,
    output t_job                  o_job,
    input  wire logic             i_job_pop
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    t_job w_job;
    logic w_keep;
    logic w_push;

    always_comb begin
        w_job.restart = i_s_restart;
        w_job.count   = (i_s_count > MAX_WORDS) ? MAX_WORDS : i_s_count;
    end

    // a zero-count word request changes nothing and is not queued
    assign w_keep      = i_s_restart || (i_s_count != '0);
    assign o_s_tready  = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign w_push      = i_s_tvalid && o_s_tready && w_keep;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_job_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({w_push, i_job_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= w_job;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/pcg4_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcg4_lane
// One lcg lane: 64-bit state and a 64x64 low-half multiply-add built from
// one 32x32 multiplier over four phases.
// ----------------------------------------------------------------------------
module pcg4_lane
    import pcg4_pkg::*;
#(
    parameter int unsigned LANE_IDX   = 0,
    parameter int unsigned LANE_COUNT = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_lane_ctl          i_ctl,
    input  wire logic [STATE_W-1:0] i_inc,
    input  wire logic [STATE_W-1:0] i_base,
    input  wire logic [STATE_W-1:0] i_jinc,
    output logic      [STATE_W-1:0] o_state,
    output logic      [WORD_W-1:0]  o_word
);

    localparam logic [STATE_W-1:0] K_SCALE     = f_sum_pow(LANE_IDX);
    localparam logic [STATE_W-1:0] K_SEED      = f_mult_pow(LANE_IDX + 1);
    localparam logic [STATE_W-1:0] K_STEP      = f_mult_pow(LANE_COUNT);
    localparam logic [STATE_W-1:0] RESET_STATE = f_lane_reset(LANE_IDX);

    logic [STATE_W-1:0] r_state;
    logic [STATE_W-1:0] r_acc;
    logic [STATE_W-1:0] r_prod;

    logic [STATE_W-1:0] w_a;
    logic [STATE_W-1:0] w_b;
    logic [STATE_W-1:0] w_d;
    logic [WORD_W-1:0]  w_mul_a;
    logic [WORD_W-1:0]  w_mul_b;
    logic [STATE_W-1:0] w_prod;

    always_comb begin
        case (i_ctl.op)
            LOP_SCALE: begin
                w_a = i_inc;
                w_b = K_SCALE;
                w_d = '0;
            end
            LOP_SEED: begin
                w_a = i_base;
                w_b = K_SEED;
                w_d = r_state;
            end
            default: begin
                w_a = r_state;
                w_b = K_STEP;
                w_d = i_jinc;
            end
        endcase
    end

    // low*low, low*high, high*low: the high*high term falls off the top
    assign w_mul_a = (i_ctl.phase == PH_CROSS_B) ? w_a[STATE_W-1:WORD_W] : w_a[WORD_W-1:0];
    assign w_mul_b = (i_ctl.phase == PH_CROSS_A) ? w_b[STATE_W-1:WORD_W] : w_b[WORD_W-1:0];
    assign w_prod  = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RESET_STATE;
        end else if (i_ctl.run && (i_ctl.phase == PH_LAST)) begin
            r_state <= r_acc + {r_prod[WORD_W-1:0], {WORD_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.run) begin
            case (i_ctl.phase)
                PH_FIRST: begin
                    r_prod <= w_prod;
                end
                PH_CROSS_A: begin
                    r_acc  <= r_prod + w_d;
                    r_prod <= w_prod;
                end
                PH_CROSS_B: begin
                    r_acc  <= r_acc + {r_prod[WORD_W-1:0], {WORD_W{1'b0}}};
                    r_prod <= w_prod;
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_state = r_state;
    assign o_word  = f_xsh_rr(r_state);

endmodule
`default_nettype wire

// ----- rtl/core/pcg4_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcg4_back
// Executes queued jobs: restarts the lanes from the seed register, refills
// the word buffer from all lanes and emits words through an output register.
// ----------------------------------------------------------------------------
module pcg4_back
    import pcg4_pkg::*;
#(
    parameter int unsigned LANE_COUNT = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CFG_W-1:0]   i_seed,
    input  wire logic               i_job_valid,
    input  wire t_job               i_job,
    output logic                    o_job_pop,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic      [WORD_W-1:0]  o_m_tdata,
    output logic                    o_m_tlast
);

    localparam int unsigned POS_W = $clog2(LANE_COUNT + 1);
    localparam int unsigned IDX_W = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
    localparam logic [POS_W-1:0] POS_EMPTY = POS_W'(LANE_COUNT);
    localparam logic [STATE_W-1:0] JINC_RESET = INC_DEFAULT * f_sum_pow(LANE_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_BASE,
        ST_SCALE,
        ST_SEED,
        ST_REFILL,
        ST_EMIT
    } t_state;

    t_state             r_st;
    logic [1:0]         r_ph;
    logic [POS_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_left;
    logic [STATE_W-1:0] r_inc;
    logic [STATE_W-1:0] r_base;
    logic [STATE_W-1:0] r_jinc;
    logic [WORD_W-1:0]  r_buf [LANE_COUNT];
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_data;
    logic               r_out_last;

    t_lane_ctl          w_ctl;
    logic [STATE_W-1:0] w_state [LANE_COUNT];
    logic [WORD_W-1:0]  w_word  [LANE_COUNT];
    logic               w_out_free;
    logic               w_load;
    logic [STATE_W-1:0] w_seq;
    logic [STATE_W-1:0] w_start;

    always_comb begin
        w_ctl.run   = (r_st == ST_SCALE) || (r_st == ST_SEED) || (r_st == ST_REFILL);
        w_ctl.phase = r_ph;
        case (r_st)
            ST_SCALE: w_ctl.op = LOP_SCALE;
            ST_SEED:  w_ctl.op = LOP_SEED;
            default:  w_ctl.op = LOP_STEP;
        endcase
    end

    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        pcg4_lane #(
            .LANE_IDX   (g),
            .LANE_COUNT (LANE_COUNT)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_inc   (r_inc),
            .i_base  (r_base),
            .i_jinc  (r_jinc),
            .o_state (w_state[g]),
            .o_word  (w_word[g])
        );
    end

    assign w_seq      = (i_seed == '0) ? SEQ_DEFAULT : i_seed;
    assign w_start    = ((START_DEFAULT ^ i_seed) == '0) ? START_DEFAULT
                                                         : (START_DEFAULT ^ i_seed);
    assign o_job_pop  = (r_st == ST_IDLE) && i_job_valid;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_load     = (r_st == ST_EMIT) && (r_pos != POS_EMPTY) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_ph        <= PH_FIRST;
            r_pos       <= POS_EMPTY;
            r_left      <= '0;
            r_inc       <= INC_DEFAULT;
            r_jinc      <= JINC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_buf[r_pos[IDX_W-1:0]];
                r_out_last  <= (r_left == CNT_W'(1));
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_st)
                ST_IDLE: begin
                    r_ph <= PH_FIRST;
                    if (i_job_valid) begin
                        r_left <= i_job.count;
                        r_st   <= i_job.restart ? ST_PREP : ST_EMIT;
                    end
                end
                ST_PREP: begin
                    r_inc  <= {w_seq[STATE_W-2:0], 1'b1};
                    r_base <= w_start;
                    r_st   <= ST_BASE;
                end
                ST_BASE: begin
                    r_base <= r_base + r_inc;
                    r_st   <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == PH_LAST) begin
                        r_st <= ST_SEED;
                    end
                end
                ST_SEED: begin
                    // after the scale pass the last lane holds inc * (1 + M + ... + M^(L-1))
                    if (r_ph == PH_FIRST) begin
                        r_jinc <= w_state[LANE_COUNT-1];
                    end
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == PH_LAST) begin
                        r_pos <= POS_EMPTY;
                        r_st  <= ST_IDLE;
                    end
                end
                ST_REFILL: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == PH_LAST) begin
                        r_pos <= '0;
                        r_st  <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    r_ph <= PH_FIRST;
                    if (r_pos == POS_EMPTY) begin
                        r_st <= ST_REFILL;
                    end else if (w_load) begin
                        r_pos  <= r_pos + POS_W'(1);
                        r_left <= r_left - CNT_W'(1);
                        if (r_left == CNT_W'(1)) begin
                            r_st <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    // words are taken from the lanes before the jump step overwrites them
    always_ff @(posedge i_clk) begin
        if ((r_st == ST_REFILL) && (r_ph == PH_FIRST)) begin
            for (int i = 0; i < LANE_COUNT; i++) begin
                r_buf[i] <= w_word[i];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire

// ----- rtl/core/pcg32_four_lane_generator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcg32_four_lane_generator
// pcg32 xsh-rr word generator with the lcg split over parallel lanes that
// each jump LANE_COUNT steps; words come out in plain sequential order.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata[2:0] word_count, tuser command
//  m_axis    out        tvalid/tready          tdata random_word, tlast last_word
//  apb       in         psel/penable/pready    seed_sequence at address 0
//
//  a word request is dispatched from the idle state and its words are then emitted
//  from the buffer; each time the buffer runs dry a refill runs a four-phase 32x32
//  multiply-add in every lane, all lanes in parallel.
//  a restart runs two prep steps (prep and base), a scale pass and a seed pass.
//  reset loads the lanes as for a zero seed; the word buffer starts empty.
//  a two-entry job queue lets requests be taken while the output stalls.
// ----------------------------------------------------------------------------
module pcg32_four_lane_generator
    import pcg4_pkg::*;
#(
    parameter int unsigned LANE_COUNT = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [2:0] word_count
    input  wire logic               s_axis_tuser,   // [0] command
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [WORD_W-1:0]  m_axis_tdata,   // [31:0] random_word
    output logic                    m_axis_tlast,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]   pwdata,
    output logic      [CFG_W-1:0]   prdata,
    output logic                    pready
);

    logic [CFG_W-1:0] r_seed;
    logic             w_cfg_wr;
    logic             w_q_valid;
    t_job             w_q_job;
    logic             w_pop;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && !paddr[3];
    assign prdata   = !paddr[3] ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (w_cfg_wr) begin
            r_seed <= pwdata;
        end
    end

    pcg4_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_count   (s_axis_tdata[CNT_W-1:0]),
        .i_s_restart (s_axis_tuser),
        .o_job_valid (w_q_valid),
        .o_job       (w_q_job),
        .i_job_pop   (w_pop)
    );

    pcg4_back #(
        .LANE_COUNT (LANE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed      (r_seed),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_job),
        .o_job_pop   (w_pop),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("job popped from empty queue");

    a_job_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && !w_pop) |=> w_q_valid)
        else $error("queued job lost without pop");

    a_seed_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && !paddr[3]) |=> (paddr[3] || (prdata == $past(pwdata))))
        else $error("seed register does not read back written value");

endmodule
`default_nettype wire
